/* src/bfvd_pkg.sv */
// ----------------------------------------------------------------------------
// bfvd_pkg
// Shared constants for the sculpt brush falloff datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bfvd_pkg;

  // Q0.16 falloff arithmetic; 1.0 needs one bit above the fraction
  localparam int FRAC_BITS = 16;
  localparam int Q_BITS    = FRAC_BITS + 1;

  typedef logic [Q_BITS-1:0] q16_t;

  localparam q16_t          ONE_Q16   = q16_t'(1) << FRAC_BITS;
  localparam logic [17:0]   THREE_Q16 = 18'd196608;
  localparam logic [15:0]   HALF_Q16  = 16'd32768;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CENTER_X = 3'd0;
  localparam cfg_idx_t CFG_CENTER_Y = 3'd1;
  localparam cfg_idx_t CFG_CENTER_Z = 3'd2;
  localparam cfg_idx_t CFG_RADIUS   = 3'd3;
  localparam cfg_idx_t CFG_STEP_X   = 3'd4;
  localparam cfg_idx_t CFG_STEP_Y   = 3'd5;
  localparam cfg_idx_t CFG_STEP_Z   = 3'd6;
  localparam cfg_idx_t CFG_ENABLE   = 3'd7;

endpackage

`default_nettype wire

/* src/bfvd_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// bfvd_sqrt_pipe
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bfvd_sqrt_pipe #(
  parameter int W    = 16,
  parameter int SB_W = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*W-1:0]  x,
  input  wire logic [SB_W-1:0] in_sb,
  output logic                 out_valid,
  output logic [W-1:0]         root,
  output logic [SB_W-1:0]      out_sb
);

  logic            v_q    [W];
  logic [W+1:0]    rem_q  [W];
  logic [W-1:0]    root_q [W];
  logic [2*W-1:0]  x_q    [W];
  logic [SB_W-1:0] sb_q   [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic            v_p;
    logic [W+1:0]    rem_p;
    logic [W-1:0]    root_p;
    logic [2*W-1:0]  x_p;
    logic [SB_W-1:0] sb_p;
    logic [W+1:0]    rem_sh;
    logic [W+1:0]    trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x;
      assign sb_p   = in_sb;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign x_p    = x_q[k-1];
      assign sb_p   = sb_q[k-1];
    end

    // bring down the next bit pair, try (2*root)*2 + 1
    assign rem_sh = {rem_p[W-1:0], x_p[2*W-1:2*W-2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_p[W-2:0], ge};
        x_q[k]    <= {x_p[2*W-3:0], 2'b00};
        sb_q[k]   <= sb_p;
      end
    end
  end

  assign out_valid = v_q[W-1];
  assign root      = root_q[W-1];
  assign out_sb    = sb_q[W-1];

endmodule

`default_nettype wire

/* src/bfvd_div_pipe.sv */
// ----------------------------------------------------------------------------
// bfvd_div_pipe
// Pipelined restoring divider: (num << 16) / den for num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module bfvd_div_pipe
  import bfvd_pkg::*;
#(
  parameter int NW   = 15,
  parameter int SB_W = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   num,
  input  wire logic [NW-1:0]   den,
  input  wire logic [SB_W-1:0] in_sb,
  output logic                 out_valid,
  output q16_t                 quot,
  output logic [SB_W-1:0]      out_sb
);

  logic            v_q   [FRAC_BITS+1];
  logic [NW-1:0]   rem_q [FRAC_BITS+1];
  q16_t            q_q   [FRAC_BITS+1];
  logic [SB_W-1:0] sb_q  [FRAC_BITS+1];

  // integer bit: a single bit is enough only while num is less than twice den
  logic ge0;
  assign ge0 = num >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= ge0 ? (num - den) : num;
      q_q[0]   <= {{(Q_BITS-1){1'b0}}, ge0};
      sb_q[0]  <= in_sb;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
    logic [NW:0] rem_sh;
    logic [NW:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_q[k-1], 1'b0};
    assign rem_sub = rem_sh - {1'b0, den};
    assign ge      = rem_sh >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
        q_q[k]   <= {q_q[k-1][Q_BITS-2:0], ge};
        sb_q[k]  <= sb_q[k-1];
      end
    end
  end

  assign out_valid = v_q[FRAC_BITS];
  assign quot      = q_q[FRAC_BITS];
  assign out_sb    = sb_q[FRAC_BITS];

endmodule

`default_nettype wire

/* src/brush_falloff_vertex_displace_unit.sv */
// Order: front stages, square root, divider, t, f and scale stages, output register.
// Throughput: one vertex per cycle; the whole pipeline advances together and
// holds while a result beat waits on m_tready.
// Square root takes one stage per result bit, the divider 17 stages.
// Reset (synchronous, rst high) clears all valid bits and config registers.
// ----------------------------------------------------------------------------
// brush_falloff_vertex_displace_unit
// Sculpt brush: smoothstep falloff displacement of streamed vertices.
// ----------------------------------------------------------------------------
`default_nettype none

module brush_falloff_vertex_displace_unit
  import bfvd_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // config write port
  input  wire logic                                   cfg_we,
  input  wire cfg_idx_t                               cfg_index,
  input  wire logic [COORD_BITS-1:0]                  cfg_wdata,
  // vertex in: base_x, base_y, base_z, offset_x, offset_y, offset_z
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // result out: new_offset_x, new_offset_y, new_offset_z
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [((3*COORD_BITS+7)/8)*8-1:0]           m_tdata,
  // result flag: in_brush
  output logic                                        m_tuser
);

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((3*C+7)/8)*8;
  localparam int SB_W  = 1 + 3*C;

  // ---------------------------------------------------------------- config
  logic [C-1:0] center [3];
  logic [C-1:0] stepv  [3];
  logic [C-2:0] radius;
  logic         enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      center  <= '{default: '0};
      stepv   <= '{default: '0};
      radius  <= '0;
      enabled <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center[0] <= cfg_wdata;
        CFG_CENTER_Y: center[1] <= cfg_wdata;
        CFG_CENTER_Z: center[2] <= cfg_wdata;
        CFG_RADIUS:   radius    <= cfg_wdata[C-2:0];
        CFG_STEP_X:   stepv[0]  <= cfg_wdata;
        CFG_STEP_Y:   stepv[1]  <= cfg_wdata;
        CFG_STEP_Z:   stepv[2]  <= cfg_wdata;
        CFG_ENABLE:   enabled   <= cfg_wdata[0];
        default:      enabled   <= enabled;
      endcase
    end
  end

  // radius squared, recomputed from the quiet config register
  logic [2*C-3:0] rsq;
  always_ff @(posedge clk) begin
    rsq <= radius * radius;
  end

  // global advance: the output register is free or being drained
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ------------------------------------------------- stage 1: |pos - centre|
  logic         v1;
  logic [C:0]   adiff1 [3];
  logic [C-1:0] off1   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_diff
    logic [C-1:0]        b;
    logic [C-1:0]        o;
    logic signed [C+1:0] d;

    assign b = s_tdata[i*C +: C];
    assign o = s_tdata[(3+i)*C +: C];
    assign d = $signed({{2{b[C-1]}}, b}) + $signed({{2{o[C-1]}}, o})
             - $signed({{2{center[i][C-1]}}, center[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        adiff1[i] <= d[C+1] ? (C+1)'(0) - d[C:0] : d[C:0];
        off1[i]   <= o;
      end
    end
  end

  // ------------------------------------- stage 2: box reject, squared terms
  logic           v2;
  logic           ins2;
  logic [2*C-3:0] sq2  [3];
  logic [C-1:0]   off2 [3];
  logic           far;

  assign far = (adiff1[0] > {2'b00, radius}) || (adiff1[1] > {2'b00, radius})
            || (adiff1[2] > {2'b00, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ins2 <= enabled && !far;
      for (int i = 0; i < 3; i++) begin
        sq2[i]  <= adiff1[i][C-2:0] * adiff1[i][C-2:0];
        off2[i] <= off1[i];
      end
    end
  end

  // ------------------------------------- stage 3: distance squared, compare
  logic           v3;
  logic           ins3;
  logic [2*C-1:0] dsq3;
  logic [3*C-1:0] off3;
  logic [2*C-1:0] dsq_sum;

  assign dsq_sum = {2'b00, sq2[0]} + {2'b00, sq2[1]} + {2'b00, sq2[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ins3 <= ins2 && (dsq_sum <= {2'b00, rsq});
      dsq3 <= dsq_sum;
      off3 <= {off2[2], off2[1], off2[0]};
    end
  end

  // -------------------------------------------------- distance = isqrt(dsq)
  logic            vs;
  logic [C-1:0]    root_d;
  logic [SB_W-1:0] sbs;

  bfvd_sqrt_pipe #(
    .W    (C),
    .SB_W (SB_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .x         (dsq3),
    .in_sb     ({ins3, off3}),
    .out_valid (vs),
    .root      (root_d),
    .out_sb    (sbs)
  );

  // --------------------------------------- ratio = distance / radius in Q0.16
  // inside the radius, the distance never exceeds it, so the top bit is zero
  logic            vd;
  q16_t            ratio;
  logic [SB_W-1:0] sbd;

  bfvd_div_pipe #(
    .NW   (C-1),
    .SB_W (SB_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vs),
    .num       (root_d[C-2:0]),
    .den       (radius),
    .in_sb     (sbs),
    .out_valid (vd),
    .quot      (ratio),
    .out_sb    (sbd)
  );

  // ----------------------------------------------- stage: t and t^2 (Q0.16)
  logic            vt;
  q16_t            t_q;
  q16_t            t2_q;
  logic [SB_W-1:0] sbt;
  q16_t            t_c;
  logic [33:0]     tt;

  assign t_c = ONE_Q16 - ratio;
  assign tt  = {17'd0, t_c} * {17'd0, t_c} + 34'(HALF_Q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (en) begin
      vt <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_q  <= t_c;
      t2_q <= tt[32:16];
      sbt  <= sbd;
    end
  end

  // ------------------------------------ stage: f = t^2 * (3 - 2t), clamped
  logic            vf;
  q16_t            f_q;
  logic [SB_W-1:0] sbf;
  logic [17:0]     k3;
  logic [35:0]     fp;
  logic [19:0]     f_raw;
  logic            use_f;

  assign k3    = THREE_Q16 - {t_q, 1'b0};
  assign fp    = {19'd0, t2_q} * {18'd0, k3} + 36'(HALF_Q16);
  assign f_raw = fp[35:16];
  // zero radius: only the centre is inside, and it is not moved
  assign use_f = sbt[SB_W-1] && (radius != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!use_f) begin
        f_q <= '0;
      end else if (f_raw > 20'(ONE_Q16)) begin
        f_q <= ONE_Q16;
      end else begin
        f_q <= f_raw[Q_BITS-1:0];
      end
      sbf <= sbt;
    end
  end

  // --------------------------------------------- stage: |step| * f per axis
  logic            vm;
  logic [C+16:0]   mp  [3];
  logic            sgn [3];
  logic [SB_W-1:0] sbm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vf;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_scale
    logic [C-1:0] smag;
    assign smag = stepv[i][C-1] ? C'(0) - stepv[i] : stepv[i];

    always_ff @(posedge clk) begin
      if (en) begin
        mp[i]  <= {{Q_BITS{1'b0}}, smag} * {{C{1'b0}}, f_q};
        sgn[i] <= stepv[i][C-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbm <= sbf;
    end
  end

  // ------------------------------ output: round, add, saturate, hold beat
  logic [C-1:0] new_off [3];

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [C+17:0]       mr;
    logic [C+1:0]        m;
    logic [C-1:0]        o;
    logic signed [C+1:0] sum;

    assign mr  = {1'b0, mp[i]} + (C+18)'(HALF_Q16);
    assign m   = mr[C+17:16];
    assign o   = sbm[i*C +: C];
    assign sum = sgn[i] ? $signed({{2{o[C-1]}}, o}) - $signed(m)
                        : $signed({{2{o[C-1]}}, o}) + $signed(m);

    always_comb begin
      if (sum > $signed({3'b000, {(C-1){1'b1}}})) begin
        new_off[i] = {1'b0, {(C-1){1'b1}}};
      end else if (sum < $signed({3'b111, {(C-1){1'b0}}})) begin
        new_off[i] = {1'b1, {(C-1){1'b0}}};
      end else begin
        new_off[i] = sum[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OUT_W'({new_off[2], new_off[1], new_off[0]});
      m_tuser <= sbm[SB_W-1];
    end
  end

  // --------------------------------------------------------------- checks
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid straight after reset");

  a_falloff_range: assert property (@(posedge clk) disable iff (rst)
    vf |-> (f_q <= ONE_Q16))
    else $error("falloff above one");

  a_outside_no_move: assert property (@(posedge clk) disable iff (rst)
    (vf && !sbf[SB_W-1]) |-> (f_q == '0))
    else $error("falloff non-zero for vertex outside brush");

endmodule

`default_nettype wire
